### src/scie_pkg.sv
// Package: constants, types and helper functions for the scramble/convolve/interleave encoder.
`timescale 1ns / 1ps
package scie_pkg;

   localparam int unsigned DataWidth    = 8;
   localparam int unsigned WordWidth    = 16;
   localparam int unsigned ScrWidth     = 18;
   localparam int unsigned HistWidth    = 4;
   localparam int unsigned PosWidth     = 4;
   localparam int unsigned ScrTapA      = 12;
   localparam int unsigned ScrTapB      = 17;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   // Register indexes, taken from byte address bits above the word offset
   localparam logic RegInjectErrors = 1'b0;

   typedef logic [DataWidth-1:0] data_type;
   typedef logic [WordWidth-1:0] word_type;
   typedef logic [ScrWidth-1:0]  scr_type;
   typedef logic [HistWidth-1:0] hist_type;
   typedef logic [PosWidth-1:0]  pos_type;

   // 4x4 bit transpose: output bit 4a+b takes input bit 4b+a
   function automatic word_type transpose4x4(input word_type w);
      word_type r;
      r = '0;
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            r[4*a+b] = w[4*b+a];
         end
      end
      return r;
   endfunction

   // Flip position (5 * position) mod 16, as shift-and-add truncated to 4 bits
   function automatic pos_type flip_position(input pos_type p);
      return pos_type'(p + {p[PosWidth-3:0], 2'b00});
   endfunction

endpackage

### src/scramble_convolve_interleave_encoder_core.sv
// Top level: scrambler, K=5 rate 1/2 convolutional encoder, 4x4 interleaver, error injection.
// Path: an accepted beat enters the input register, then goes through one pass of XOR logic
//   into the result register, which drives rsp_.
// Throughput: one beat per cycle while rsp_stall is low; the scrambler and encoder
//   history update in the same cycle that a beat moves from input into result register.
// Reset: synchronous, active high; clears both stages, scrambler, history and byte count,
//   and sets inject_errors to 1.
`timescale 1ns / 1ps
module scramble_convolve_interleave_encoder_core
   import scie_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input beats
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [DataWidth-1:0]    req_data_byte,
   input  logic                    req_frame_start,
   // result beats
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [WordWidth-1:0]    rsp_code_word,
   // configuration port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   // Input stage
   logic     in_valid_ff, in_valid_in;
   data_type in_data_ff;
   logic     in_start_ff;

   // Result stage
   logic     out_valid_ff, out_valid_in;
   word_type out_word_ff;

   // Running state
   scr_type  scr_ff, scr_in;
   hist_type hist_ff, hist_in;
   pos_type  pos_ff, pos_in;
   logic     inject_ff, inject_in;

   logic     req_take;
   logic     out_load;
   logic     csr_write;
   word_type enc_word;
   word_type flip_mask;

   // Pipeline moves
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   // Scramble, encode and interleave the held byte, LSB first
   always_comb begin
      scr_type  shift;
      hist_type hist;
      logic     bit_s;
      logic [HistWidth:0] win;
      word_type word;
      shift = in_start_ff ? '0 : scr_ff;
      hist  = in_start_ff ? '0 : hist_ff;
      word  = '0;
      for (int j = 0; j < DataWidth; j++) begin
         bit_s = in_data_ff[j] ^ shift[ScrTapA] ^ shift[ScrTapB];
         shift = {shift[ScrWidth-2:0], bit_s};
         win   = {hist, bit_s};
         word[2*j]   = win[0] ^ win[3] ^ win[4];
         word[2*j+1] = win[0] ^ win[1] ^ win[2] ^ win[4];
         hist  = win[HistWidth-1:0];
      end
      scr_in   = shift;
      hist_in  = hist;
      enc_word = transpose4x4(word);
   end

   // Injected error bit rotates with the byte count
   always_comb begin
      pos_type p;
      p         = in_start_ff ? '0 : pos_ff;
      flip_mask = inject_ff ? (word_type'(1) << flip_position(p)) : '0;
      pos_in    = pos_type'(p + pos_type'(1));
   end

   // Configuration register
   assign csr_write = psel && penable && pwrite && pready;
   assign inject_in = (csr_write && paddr[2] == RegInjectErrors) ? pwdata[0] : inject_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == RegInjectErrors) ?
                      {{(CsrDataWidth-1){1'b0}}, inject_ff} : '0;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         scr_ff       <= '0;
         hist_ff      <= '0;
         pos_ff       <= '0;
         inject_ff    <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         inject_ff    <= inject_in;
         if (out_load) begin
            scr_ff  <= scr_in;
            hist_ff <= hist_in;
            pos_ff  <= pos_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
      if (out_load) begin
         out_word_ff <= enc_word ^ flip_mask;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code_word = out_word_ff;

`ifndef ASSERT_OFF
   // Reset empties both stages
   assert property (@(posedge clock) reset |=> !in_valid_ff && !out_valid_ff)
      else $error("stages not empty after reset");

   // An accepted beat lands in the input stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted beat lost");

   // A frame-start byte leaves the byte count at one
   assert property (@(posedge clock) disable iff (reset)
      out_load && in_start_ff |=> pos_ff == pos_type'(1))
      else $error("byte count not restarted by frame start");

   // A held input beat must wait while the result stage stays full
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |-> req_stall && !out_load)
      else $error("input stage advanced into a stalled result");
`endif

endmodule

### tb/tb.sv
// Self-checking bench for the scrambler, convolutional encoder and interleaver core.
`timescale 1ns / 1ps
module tb;
   import scie_pkg::*;

   localparam int unsigned IdleLimit = 2000;
   localparam int unsigned PrintCap  = 40;
   localparam logic [CsrAddrWidth-1:0] InjectAddr = CsrAddrWidth'({RegInjectErrors, 2'b00});

   // One directed beat: the code word is typed in only where it is obvious
   typedef struct packed {
      data_type data;
      logic     frame_start;
      logic     fixed;
      word_type code_word;
   } directed_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [DataWidth-1:0]    req_data_byte = '0;
   logic                    req_frame_start = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [WordWidth-1:0]    rsp_code_word;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   // Encoder state as predicted from accepted beats
   scr_type  scr_state = '0;
   hist_type hist_state = '0;
   pos_type  pos_state = '0;
   logic     inject_state = 1'b1;

   word_type pending_words[$];
   int       fail_count = 0;
   int       stall_pct = 0;
   int       stall_left = 0;
   int       idle_cycles = 0;

   directed_row_type directed_rows[24];

   scramble_convolve_interleave_encoder_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_code_word(rsp_code_word),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // Scramble, convolve and interleave one byte, flip the injected bit if enabled, then advance the byte count
   function automatic word_type encode_byte(input data_type data, input logic frame_start);
      word_type   pairs;
      word_type   word;
      logic       sbit;
      logic [4:0] win;
      if (frame_start) begin
         scr_state = '0;
         hist_state = '0;
         pos_state = '0;
      end
      pairs = '0;
      for (int j = 0; j < 8; j++) begin
         sbit = data[j] ^ scr_state[ScrTapA] ^ scr_state[ScrTapB];
         scr_state = {scr_state[ScrWidth-2:0], sbit};
         win = {hist_state, sbit};
         pairs[2*j]   = win[0] ^ win[3] ^ win[4];
         pairs[2*j+1] = win[0] ^ win[1] ^ win[2] ^ win[4];
         hist_state = win[3:0];
      end
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            word[4*a+b] = pairs[4*b+a];
         end
      end
      if (inject_state) begin
         word[(5 * int'(pos_state)) % 16] = ~word[(5 * int'(pos_state)) % 16];
      end
      pos_state = pos_state + 1'b1;
      return word;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < PrintCap) begin
         $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
      end
      fail_count++;
   endtask

   // Hold the beat until it is taken, then record its code word
   task automatic send_beat(input data_type data, input logic frame_start,
                            input logic fixed, input word_type fixed_word);
      word_type w;
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      w = encode_byte(data, frame_start);
      pending_words.push_back(fixed ? fixed_word : w);
   endtask

   // Drop valid and let the pipeline drain before touching a register
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write a register, then leave the port idle
   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr,
                            input logic [CsrDataWidth-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == InjectAddr) inject_state = value[0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [CsrAddrWidth-1:0] addr,
                            input logic [CsrDataWidth-1:0] want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) report_mismatch("inject_errors readback", prdata, want);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Send random beats in bursts; frames restart at random, sometimes very often
   task automatic run_phase(input int beats, input int gap_max, input int burst_max,
                            input int start_pct);
      int       sent;
      int       burst;
      int       gap;
      data_type data;
      sent = 0;
      while (sent < beats) begin
         burst = $urandom_range(1, burst_max);
         for (int k = 0; k < burst && sent < beats; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else begin
               data = data_type'($urandom_range(0, 255));
            end
            send_beat(data, $urandom_range(0, 99) < start_pct, 1'b0, '0);
            sent++;
         end
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Receiver stall pattern: runs of random length, high with the phase's odds
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         stall_left <= $urandom_range(1, 8);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // Check each result beat against the oldest pending code word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch("code_word with nothing pending", 32'(rsp_code_word), 32'h0);
         end else if (rsp_code_word !== pending_words[0]) begin
            report_mismatch("code_word", 32'(rsp_code_word), 32'(pending_words[0]));
            void'(pending_words.pop_front());
         end else begin
            void'(pending_words.pop_front());
         end
      end
   end

   // End the run when no beat or register access has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("scramble_convolve_interleave_encoder_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // After reset: zero data gives a zero word plus the injected bit
      directed_rows[0]  = '{8'h00, 1'b0, 1'b1, 16'h0001};
      directed_rows[1]  = '{8'h00, 1'b0, 1'b1, 16'h0020};
      directed_rows[2]  = '{8'hFF, 1'b0, 1'b0, 16'h0000};
      directed_rows[3]  = '{8'h01, 1'b0, 1'b0, 16'h0000};
      directed_rows[4]  = '{8'h80, 1'b0, 1'b0, 16'h0000};
      directed_rows[5]  = '{8'hAA, 1'b0, 1'b0, 16'h0000};
      directed_rows[6]  = '{8'h55, 1'b0, 1'b0, 16'h0000};
      // Frame start clears everything before its own byte
      directed_rows[7]  = '{8'h00, 1'b1, 1'b1, 16'h0001};
      directed_rows[8]  = '{8'h00, 1'b0, 1'b1, 16'h0020};
      directed_rows[9]  = '{8'h00, 1'b0, 1'b1, 16'h0400};
      directed_rows[10] = '{8'h00, 1'b0, 1'b1, 16'h8000};
      directed_rows[11] = '{8'hFF, 1'b0, 1'b0, 16'h0000};
      directed_rows[12] = '{8'hFF, 1'b0, 1'b0, 16'h0000};
      directed_rows[13] = '{8'h0F, 1'b0, 1'b0, 16'h0000};
      directed_rows[14] = '{8'hF0, 1'b0, 1'b0, 16'h0000};
      directed_rows[15] = '{8'h3C, 1'b0, 1'b0, 16'h0000};
      directed_rows[16] = '{8'hC3, 1'b0, 1'b0, 16'h0000};
      directed_rows[17] = '{8'h01, 1'b0, 1'b0, 16'h0000};
      directed_rows[18] = '{8'h02, 1'b0, 1'b0, 16'h0000};
      directed_rows[19] = '{8'h04, 1'b0, 1'b0, 16'h0000};
      directed_rows[20] = '{8'h08, 1'b0, 1'b0, 16'h0000};
      directed_rows[21] = '{8'h10, 1'b0, 1'b0, 16'h0000};
      directed_rows[22] = '{8'h20, 1'b0, 1'b0, 16'h0000};
      // Byte count wraps from 15 back to 0 here
      directed_rows[23] = '{8'h40, 1'b0, 1'b0, 16'h0000};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      csr_check(InjectAddr, 32'h1);
      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].data, directed_rows[i].frame_start,
                   directed_rows[i].fixed, directed_rows[i].code_word);
      end

      // Random phases, alternating injection off and on, with varied idling
      wait_idle();
      csr_write(InjectAddr, 32'h0);
      csr_check(InjectAddr, 32'h0);
      stall_pct = 0;
      run_phase(150, 0, 50, 5);

      wait_idle();
      csr_write(InjectAddr, 32'h1);
      csr_check(InjectAddr, 32'h1);
      stall_pct = 30;
      run_phase(150, 3, 8, 5);

      wait_idle();
      csr_write(InjectAddr, 32'h0);
      stall_pct = 60;
      run_phase(150, 6, 4, 3);

      wait_idle();
      csr_write(InjectAddr, 32'h1);
      stall_pct = 10;
      run_phase(150, 1, 20, 40);

      wait_idle();
      csr_write(InjectAddr, 32'h0);
      stall_pct = 80;
      run_phase(120, 4, 6, 6);

      wait_idle();
      csr_write(InjectAddr, 32'h1);
      stall_pct = 50;
      run_phase(120, 2, 12, 5);

      // Drain, then let the pipeline settle before the verdict
      wait_idle();
      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("scramble_convolve_interleave_encoder_core: match");
      end else begin
         $display("scramble_convolve_interleave_encoder_core: mismatch");
      end
      $finish;
   end

endmodule
